// File: rtl/ppdm_pkg.sv
`default_nettype none

package ppdm_pkg;

    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned DUTY_W   = 10;
    localparam int unsigned THR_W    = 10;
    localparam int unsigned SCALED_W = STAMP_W + DUTY_W;
    localparam int unsigned DIV_STEPS = SCALED_W;
    localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1000);

    typedef enum logic [1:0] {
        OP_RISE   = 2'd0,
        OP_FALL   = 2'd1,
        OP_DETECT = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CLASS_HIGH = 2'd0,
        CLASS_LOW  = 2'd1,
        CLASS_PWM  = 2'd2,
        CLASS_NONE = 2'd3
    } pilot_class_t;

    typedef enum logic {
        REG_LOW_THR  = 1'b0,
        REG_HIGH_THR = 1'b1
    } reg_index_t;

    localparam logic [THR_W-1:0] LOW_THR_RESET  = THR_W'(5);
    localparam logic [THR_W-1:0] HIGH_THR_RESET = THR_W'(985);

    // status from the divider back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// File: rtl/ppdm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ppdm_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [ppdm_pkg::SCALED_W-1:0]      dividend,
    input  wire logic [ppdm_pkg::STAMP_W-1:0]       divisor,
    output ppdm_pkg::div_status_t                   status,
    output logic      [ppdm_pkg::SCALED_W-1:0]      quotient,
    output logic      [ppdm_pkg::STAMP_W-1:0]       remainder
);

    logic                              busy_reg;
    logic [ppdm_pkg::STEP_W-1:0]       step_reg;
    logic [ppdm_pkg::SCALED_W-1:0]     quo_reg;
    logic [ppdm_pkg::STAMP_W-1:0]      rem_reg;
    logic [ppdm_pkg::STAMP_W-1:0]      dsr_reg;

    logic [ppdm_pkg::STAMP_W:0]        rem_shift;
    logic [ppdm_pkg::STAMP_W:0]        rem_diff;
    logic                              fits;
    logic                              last_step;

    assign rem_shift = {rem_reg, quo_reg[ppdm_pkg::SCALED_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});
    assign last_step = (step_reg == ppdm_pkg::STEP_W'(ppdm_pkg::DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (last_step) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops cleanly
            rem_reg <= fits ? rem_diff[ppdm_pkg::STAMP_W-1:0]
                            : rem_shift[ppdm_pkg::STAMP_W-1:0];
            quo_reg <= {quo_reg[ppdm_pkg::SCALED_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && last_step;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

// File: rtl/pilot_pwm_duty_measure.sv
`default_nettype none

// Pilot PWM duty measurement. Each item carries a timer stamp of a rising or
// falling pilot edge, or asks for a detect. A rising item yields the period
// since the previous rising stamp (mod 2^32); a falling item yields the
// on-time, the duty in per-mille (floor, saturated at 1000) and the two
// threshold flags; a detect item classifies the pilot as static high/low
// (from pin_level) when a flag is set, PWM otherwise. Every item gives one
// result carrying the current period, on-time, duty, class and a divide-error
// bit (falling edge with zero period; duty and flags then keep old values).
// Rising, detect and unused-opcode items pass ST_FINISH to the result load.
// A falling item passes ST_LOAD (scales the on-time by 1000), 42 steps of
// the one-bit-per-cycle restoring divider, ST_WRAP (derives duty and flags
// from quotient and remainder) and the result load. The result sits in an
// output register, so a new item may be accepted while it waits. The user
// writes thresholds through cfg_* only while idle, unenforced by the block.
module pilot_pwm_duty_measure (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_index,
    input  wire logic [ppdm_pkg::THR_W-1:0]         cfg_wdata,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_opcode,
    input  wire logic [ppdm_pkg::STAMP_W-1:0]       s_capture_value,
    input  wire logic                               s_pin_level,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [ppdm_pkg::STAMP_W-1:0]       m_period_counts,
    output logic      [ppdm_pkg::STAMP_W-1:0]       m_on_counts,
    output logic      [ppdm_pkg::DUTY_W-1:0]        m_duty_permille,
    output logic      [1:0]                         m_pilot_state,
    output logic                                    m_divide_error
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_WRAP   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ppdm_pkg::THR_W-1:0]     low_thr_reg;
    logic [ppdm_pkg::THR_W-1:0]     high_thr_reg;
    logic [ppdm_pkg::STAMP_W-1:0]   last_rise_reg;
    logic [ppdm_pkg::STAMP_W-1:0]   period_reg;
    logic [ppdm_pkg::STAMP_W-1:0]   on_time_reg;
    logic [ppdm_pkg::DUTY_W-1:0]    duty_reg;
    logic                           below_reg;
    logic                           above_reg;
    ppdm_pkg::pilot_class_t         class_reg;
    logic                           err_reg;
    logic                           m_valid_reg;

    logic                           in_accept;
    logic                           out_free;
    ppdm_pkg::opcode_t              op;
    logic [ppdm_pkg::SCALED_W-1:0]  on_ext;
    logic [ppdm_pkg::SCALED_W-1:0]  scaled;
    logic                           div_start;
    ppdm_pkg::div_status_t          div_status;
    logic [ppdm_pkg::SCALED_W-1:0]  quo;
    logic [ppdm_pkg::STAMP_W-1:0]   rem;
    logic                           quo_hi;
    logic [ppdm_pkg::DUTY_W-1:0]    quo_lo;

    assign op        = ppdm_pkg::opcode_t'(s_opcode);
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // x * 1000 = (x << 10) - (x << 4) - (x << 3)
    assign on_ext = ppdm_pkg::SCALED_W'(on_time_reg);
    assign scaled = (on_ext << 10) - (on_ext << 4) - (on_ext << 3);

    assign div_start = (state_reg == ST_LOAD) && (period_reg != '0);

    ppdm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (scaled),
        .divisor   (period_reg),
        .status    (div_status),
        .quotient  (quo),
        .remainder (rem)
    );

    assign quo_hi = |quo[ppdm_pkg::SCALED_W-1:ppdm_pkg::DUTY_W];
    assign quo_lo = quo[ppdm_pkg::DUTY_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (op == ppdm_pkg::OP_FALL) ? ST_LOAD : ST_FINISH;
                end
            end
            ST_LOAD: begin
                state_next = (period_reg == '0) ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            low_thr_reg   <= ppdm_pkg::LOW_THR_RESET;
            high_thr_reg  <= ppdm_pkg::HIGH_THR_RESET;
            last_rise_reg <= '0;
            period_reg    <= '0;
            on_time_reg   <= '0;
            duty_reg      <= '0;
            below_reg     <= 1'b1;
            above_reg     <= 1'b0;
            class_reg     <= ppdm_pkg::CLASS_NONE;
            err_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (ppdm_pkg::reg_index_t'(cfg_index))
                    ppdm_pkg::REG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                    ppdm_pkg::REG_HIGH_THR: high_thr_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (in_accept) begin
                err_reg <= 1'b0;
                unique case (op)
                    ppdm_pkg::OP_RISE: begin
                        period_reg    <= s_capture_value - last_rise_reg;
                        last_rise_reg <= s_capture_value;
                    end
                    ppdm_pkg::OP_FALL: begin
                        on_time_reg <= s_capture_value - last_rise_reg;
                    end
                    ppdm_pkg::OP_DETECT: begin
                        if (below_reg || above_reg) begin
                            class_reg <= s_pin_level ? ppdm_pkg::CLASS_HIGH
                                                     : ppdm_pkg::CLASS_LOW;
                        end else begin
                            class_reg <= ppdm_pkg::CLASS_PWM;
                        end
                    end
                    default: ;
                endcase
            end

            if (state_reg == ST_LOAD && period_reg == '0) begin
                err_reg <= 1'b1;
            end

            // scaled = q * period + r with r < period, so the rational
            // compares reduce to compares on q (and r for the tie)
            if (state_reg == ST_WRAP) begin
                duty_reg  <= (quo_hi || quo_lo > ppdm_pkg::DUTY_FULL)
                             ? ppdm_pkg::DUTY_FULL : quo_lo;
                below_reg <= !quo_hi && (quo_lo < low_thr_reg);
                above_reg <= quo_hi || (quo_lo > high_thr_reg)
                             || (quo_lo == high_thr_reg && rem != '0);
            end

            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_period_counts <= period_reg;
            m_on_counts     <= on_time_reg;
            m_duty_permille <= duty_reg;
            m_pilot_state   <= class_reg;
            m_divide_error  <= err_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: dv/pilot_duty_checker.sv
module pilot_duty_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [ppdm_pkg::THR_W-1:0]   cfg_wdata,

    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic [1:0]                   s_opcode,
    input  wire logic [ppdm_pkg::STAMP_W-1:0] s_capture_value,
    input  wire logic                         s_pin_level,

    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic [ppdm_pkg::STAMP_W-1:0] m_period_counts,
    input  wire logic [ppdm_pkg::STAMP_W-1:0] m_on_counts,
    input  wire logic [ppdm_pkg::DUTY_W-1:0]  m_duty_permille,
    input  wire logic [1:0]                   m_pilot_state,
    input  wire logic                         m_divide_error,

    output int unsigned                       results_due,
    output int unsigned                       mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppdm_pkg::*;

    localparam int unsigned MAX_REPORTS = 200;

    typedef struct packed {
        logic [STAMP_W-1:0] period;
        logic [STAMP_W-1:0] on_time;
        logic [DUTY_W-1:0]  duty;
        pilot_class_t       state;
        logic               div_err;
    } pilot_reading_t;

    // shadow of the block's registers and measurement state
    logic [THR_W-1:0]   low_thr;
    logic [THR_W-1:0]   high_thr;
    logic [STAMP_W-1:0] rise_stamp;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] on_time;
    logic [DUTY_W-1:0]  duty;
    logic               below_low;
    logic               above_high;
    pilot_class_t       pilot_cls;

    pilot_reading_t     expected_readings[$];
    int unsigned        errors;
    int unsigned        reports_printed;

    assign mismatch_count = errors;

    initial begin
        errors          = 0;
        reports_printed = 0;
    end

    function automatic pilot_reading_t predict_reading(opcode_t op, logic [STAMP_W-1:0] stamp,
                                                       logic pin);
        logic [SCALED_W-1:0] scaled;
        logic [63:0]         quot;
        pilot_reading_t      r;
        r.div_err = 1'b0;
        case (op)
            OP_RISE: begin
                period     = stamp - rise_stamp;
                rise_stamp = stamp;
            end
            OP_FALL: begin
                on_time = stamp - rise_stamp;
                // zero period: on-time moves, duty and flags hold
                if (period == '0) begin
                    r.div_err = 1'b1;
                end else begin
                    scaled     = SCALED_W'(on_time) * SCALED_W'(DUTY_FULL);
                    quot       = 64'(scaled) / 64'(period);
                    duty       = (quot > 64'(DUTY_FULL)) ? DUTY_FULL : DUTY_W'(quot);
                    below_low  = 64'(scaled) < 64'(low_thr) * 64'(period);
                    above_high = 64'(scaled) > 64'(high_thr) * 64'(period);
                end
            end
            OP_DETECT: begin
                if (below_low || above_high) begin
                    pilot_cls = pin ? CLASS_HIGH : CLASS_LOW;
                end else begin
                    pilot_cls = CLASS_PWM;
                end
            end
            default: ;
        endcase
        r.period  = period;
        r.on_time = on_time;
        r.duty    = duty;
        r.state   = pilot_cls;
        return r;
    endfunction

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        if (reports_printed < MAX_REPORTS) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            reports_printed++;
        end
    endtask

    always @(posedge aclk) begin
        pilot_reading_t want;
        if (!aresetn) begin
            low_thr    = LOW_THR_RESET;
            high_thr   = HIGH_THR_RESET;
            rise_stamp = '0;
            period     = '0;
            on_time    = '0;
            duty       = '0;
            below_low  = 1'b1;
            above_high = 1'b0;
            pilot_cls  = CLASS_NONE;
            expected_readings.delete();
        end else begin
            if (cfg_wr_en) begin
                if (reg_index_t'(cfg_index) == REG_LOW_THR) begin
                    low_thr = cfg_wdata;
                end else begin
                    high_thr = cfg_wdata;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    errors++;
                    if (reports_printed < MAX_REPORTS) begin
                        $display("%0t: result expected none actual period %0d on %0d duty %0d",
                                 $time, m_period_counts, m_on_counts, m_duty_permille);
                        reports_printed++;
                    end
                end else begin
                    want = expected_readings.pop_front();
                    if (m_period_counts !== want.period)
                        report_field("period_counts", 64'(want.period), 64'(m_period_counts));
                    if (m_on_counts !== want.on_time)
                        report_field("on_counts", 64'(want.on_time), 64'(m_on_counts));
                    if (m_duty_permille !== want.duty)
                        report_field("duty_permille", 64'(want.duty), 64'(m_duty_permille));
                    if (m_pilot_state !== want.state)
                        report_field("pilot_state", 64'(want.state), 64'(m_pilot_state));
                    if (m_divide_error !== want.div_err)
                        report_field("divide_error", 64'(want.div_err), 64'(m_divide_error));
                end
            end
            if (s_valid && s_ready) begin
                expected_readings.push_back(predict_reading(opcode_t'(s_opcode),
                                                            s_capture_value, s_pin_level));
            end
        end
        results_due <= expected_readings.size();
    end

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppdm_pkg::*;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned DRAIN_TAIL  = 60;
    localparam int unsigned PHASE_ITEMS = 190;
    localparam int unsigned PHASES      = 9;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_index;
    logic [THR_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_opcode;
    logic [STAMP_W-1:0]   s_capture_value;
    logic                 s_pin_level;
    logic                 m_valid;
    logic                 m_ready;
    logic [STAMP_W-1:0]   m_period_counts;
    logic [STAMP_W-1:0]   m_on_counts;
    logic [DUTY_W-1:0]    m_duty_permille;
    logic [1:0]           m_pilot_state;
    logic                 m_divide_error;

    int unsigned          results_due;
    int unsigned          mismatch_count;

    // stimulus state
    logic [STAMP_W-1:0]   timer_now;
    logic [THR_W-1:0]     low_set;
    logic [THR_W-1:0]     high_set;
    int unsigned          items_sent;
    int unsigned          burst_left;
    bit                   steady_send;
    bit                   hold_request;
    int unsigned          idle_cycles;

    pilot_pwm_duty_measure dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_capture_value (s_capture_value),
        .s_pin_level     (s_pin_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_period_counts (m_period_counts),
        .m_on_counts     (m_on_counts),
        .m_duty_permille (m_duty_permille),
        .m_pilot_state   (m_pilot_state),
        .m_divide_error  (m_divide_error)
    );

    pilot_duty_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_capture_value (s_capture_value),
        .s_pin_level     (s_pin_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_period_counts (m_period_counts),
        .m_on_counts     (m_on_counts),
        .m_duty_permille (m_duty_permille),
        .m_pilot_state   (m_pilot_state),
        .m_divide_error  (m_divide_error),
        .results_due     (results_due),
        .mismatch_count  (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1, 0));
    endfunction

    // hold valid and payload until the item is taken
    task automatic send(opcode_t op, logic [STAMP_W-1:0] stamp, logic pin);
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_capture_value <= stamp;
        s_pin_level     <= pin;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause(int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // sender in bursts with random gaps
    task automatic offer(opcode_t op, logic [STAMP_W-1:0] stamp, logic pin);
        int unsigned gap;
        send(op, stamp, pin);
        items_sent++;
        if (steady_send) return;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap != 0) pause(gap);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    task automatic set_thresholds(logic [THR_W-1:0] lo, logic [THR_W-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LOW_THR;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_HIGH_THR;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        low_set  = lo;
        high_set = hi;
    endtask

    // receiver: segments of different stall patterns, plus one long hold-off on request
    initial begin
        int unsigned mode;
        int unsigned seg_len;
        int unsigned beat;
        m_ready <= 1'b0;
        beat = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            mode    = $urandom_range(3, 0);
            seg_len = $urandom_range(300, 20);
            repeat (seg_len) begin
                if (hold_request) begin
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    hold_request = 1'b0;
                end else begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= rand_bit();
                        2: m_ready <= ($urandom_range(6, 0) != 0);
                        default: m_ready <= (beat % 5) != 4;
                    endcase
                    beat++;
                    @(posedge aclk);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [STAMP_W-1:0] per;
        logic [STAMP_W-1:0] on;
        int unsigned        target;
        int unsigned        reps;
        int unsigned        roll;

        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_LOW_THR;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_opcode        <= OP_RISE;
        s_capture_value <= '0;
        s_pin_level     <= 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        steady_send  = 1'b0;
        hold_request = 1'b0;
        low_set      = LOW_THR_RESET;
        high_set     = HIGH_THR_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset thresholds
        offer(OP_NONE, 32'hFFFF_FFFF, 1'b1);     // unused opcode reports reset state
        offer(OP_FALL, 32'h1234_5678, 1'b0);     // fall before any period
        offer(OP_DETECT, 32'h0, 1'b1);           // below flag set out of reset
        offer(OP_DETECT, 32'hFFFF_FFFF, 1'b0);
        offer(OP_RISE, 32'd1000, 1'b0);          // first rise measured from zero
        offer(OP_RISE, 32'd2000, 1'b1);
        offer(OP_FALL, 32'd2500, 1'b0);
        offer(OP_DETECT, 32'h0, 1'b0);           // PWM
        offer(OP_FALL, 32'd3000, 1'b0);          // full duty
        offer(OP_FALL, 32'd3500, 1'b1);          // on-time past period
        offer(OP_DETECT, 32'h0, 1'b1);
        offer(OP_FALL, 32'd2005, 1'b0);          // exactly at low threshold
        offer(OP_FALL, 32'd2004, 1'b0);          // just below
        offer(OP_FALL, 32'd2985, 1'b0);          // exactly at high threshold
        offer(OP_FALL, 32'd2986, 1'b0);          // just above
        offer(OP_DETECT, 32'h0, 1'b0);
        offer(OP_RISE, 32'hFFFF_FFFF, 1'b0);
        offer(OP_RISE, 32'h0000_0010, 1'b1);     // stamp wraps
        offer(OP_FALL, 32'h0000_0008, 1'b0);     // on-time wraps
        offer(OP_RISE, 32'h0000_0010, 1'b0);     // zero period
        offer(OP_FALL, 32'h0000_0018, 1'b1);
        offer(OP_RISE, 32'h0000_0000, 1'b0);
        offer(OP_RISE, 32'hFFFF_FFFF, 1'b1);
        offer(OP_FALL, 32'hFFFF_FFFE, 1'b0);     // largest period and on-time
        drain();

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_thresholds(10'd0, 10'd1000);
                1: set_thresholds(10'd1000, 10'd0);
                2: set_thresholds(10'd1023, 10'd1023);
                3: set_thresholds(10'd0, 10'd0);
                4: set_thresholds(10'd500, 10'd500);
                5, 6: set_thresholds(THR_W'($urandom_range(1023, 0)),
                                     THR_W'($urandom_range(1023, 0)));
                7: set_thresholds(10'd1000, 10'd1000);
                default: set_thresholds(LOW_THR_RESET, HIGH_THR_RESET);
            endcase
            timer_now = $urandom();

            // fill the block while the receiver holds off
            if (phase == 0) begin
                hold_request = 1'b1;
                steady_send  = 1'b1;
                repeat (40) offer(opcode_t'($urandom_range(3, 0)), $urandom(), rand_bit());
                steady_send  = 1'b0;
                drain();
            end

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                roll = $urandom_range(99, 0);
                if (roll < 70) begin
                    // well-formed pilot cycles sharing one period
                    case ($urandom_range(9, 0))
                        0:       per = '0;
                        1, 2, 3: per = $urandom_range(50, 1);
                        4, 5, 6: per = 1000 * $urandom_range(4000, 1);
                        7, 8:    per = $urandom_range(2000000, 100);
                        default: per = $urandom();
                    endcase
                    steady_send = ($urandom_range(5, 0) == 0);
                    reps = $urandom_range(4, 1);
                    repeat (reps) begin
                        case ($urandom_range(7, 0))
                            0: on = '0;
                            1: on = per;
                            // around the threshold boundaries when the period divides evenly
                            2: on = low_set * (per / 1000) + $urandom_range(2, 0) - 1;
                            3: on = high_set * (per / 1000) + $urandom_range(2, 0) - 1;
                            4: on = per + $urandom_range(100, 1);
                            default: on = (per == 0) ? $urandom_range(20, 0)
                                                     : $urandom_range(per, 0);
                        endcase
                        offer(OP_RISE, timer_now, rand_bit());
                        if ($urandom_range(7, 0) != 0)
                            offer(OP_FALL, timer_now + on, rand_bit());
                        if ($urandom_range(2, 0) == 0)
                            offer(OP_DETECT, $urandom(), rand_bit());
                        timer_now += per;
                    end
                    steady_send = 1'b0;
                end else if (roll < 82) begin
                    repeat ($urandom_range(4, 1))
                        offer(opcode_t'($urandom_range(3, 0)), $urandom(), rand_bit());
                end else if (roll < 90) begin
                    // repeated rise stamp, then a fall on the zero period
                    offer(OP_RISE, timer_now, rand_bit());
                    offer(OP_RISE, timer_now, rand_bit());
                    offer(OP_FALL, timer_now + $urandom_range(5000, 0), rand_bit());
                    offer(OP_DETECT, $urandom(), rand_bit());
                end else if (roll < 97) begin
                    // out-of-order edges
                    offer(OP_FALL, timer_now + $urandom_range(5000, 0), rand_bit());
                    offer(OP_FALL, timer_now + $urandom(), rand_bit());
                    offer(OP_DETECT, $urandom(), rand_bit());
                end else begin
                    drain();
                end
            end
            drain();
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
